// File: rtl/core/trial_division_prime_test_defines.svh
// Assertion helpers shared by the RTL. The including module must have clk and
// arst_n in scope. Each macro expands to one labeled concurrent assertion.
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDPT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/tdpt_pkg.sv
`default_nettype none

package tdpt_pkg;

	// Width of the stream payload fields.
	localparam int unsigned CAND_W = 32;

	// Microcode sizing.
	localparam int unsigned PC_W   = 4;
	localparam int unsigned COND_W = 4;

	// Jump condition codes.
	localparam logic [COND_W-1:0] COND_NEVER       = 4'd0;
	localparam logic [COND_W-1:0] COND_ALWAYS      = 4'd1;
	localparam logic [COND_W-1:0] COND_NO_REQUEST  = 4'd2;
	localparam logic [COND_W-1:0] COND_BELOW_TWO   = 4'd3;
	localparam logic [COND_W-1:0] COND_IS_TWO      = 4'd4;
	localparam logic [COND_W-1:0] COND_EVEN        = 4'd5;
	localparam logic [COND_W-1:0] COND_SQ_ABOVE    = 4'd6;
	localparam logic [COND_W-1:0] COND_DIV_BUSY    = 4'd7;
	localparam logic [COND_W-1:0] COND_REM_ZERO    = 4'd8;
	localparam logic [COND_W-1:0] COND_OUT_BLOCKED = 4'd9;

	// Program addresses.
	localparam logic [PC_W-1:0] PC_WAIT      = 4'd0;
	localparam logic [PC_W-1:0] PC_LT2       = 4'd1;
	localparam logic [PC_W-1:0] PC_EQ2       = 4'd2;
	localparam logic [PC_W-1:0] PC_EVEN      = 4'd3;
	localparam logic [PC_W-1:0] PC_LOOP      = 4'd4;
	localparam logic [PC_W-1:0] PC_DIV_WAIT  = 4'd5;
	localparam logic [PC_W-1:0] PC_CHECK     = 4'd6;
	localparam logic [PC_W-1:0] PC_BACK      = 4'd7;
	localparam logic [PC_W-1:0] PC_YES       = 4'd8;
	localparam logic [PC_W-1:0] PC_EMIT      = 4'd9;
	localparam logic [PC_W-1:0] PC_RESTART   = 4'd10;
	localparam logic [PC_W-1:0] PC_NO        = 4'd11;
	localparam logic [PC_W-1:0] PC_TO_EMIT   = 4'd12;

	// One control word. Actions take effect only when the jump is not taken.
	typedef struct packed {
		logic              accept;
		logic              div_start;
		logic              step_div;
		logic              flag_wr;
		logic              flag_val;
		logic              emit;
		logic [COND_W-1:0] cond;
		logic [PC_W-1:0]   target;
	} ctrl_t;

	// Control store.
	function automatic ctrl_t microcode(input logic [PC_W-1:0] pc);
		ctrl_t w;
		w = '0;
		w.cond = COND_ALWAYS;
		w.target = PC_WAIT;
		case (pc)
			PC_WAIT: begin
				w.accept = 1'b1;
				w.cond = COND_NO_REQUEST;
				w.target = PC_WAIT;
			end
			PC_LT2: begin
				w.cond = COND_BELOW_TWO;
				w.target = PC_NO;
			end
			PC_EQ2: begin
				w.cond = COND_IS_TWO;
				w.target = PC_YES;
			end
			PC_EVEN: begin
				w.cond = COND_EVEN;
				w.target = PC_NO;
			end
			PC_LOOP: begin
				w.div_start = 1'b1;
				w.cond = COND_SQ_ABOVE;
				w.target = PC_YES;
			end
			PC_DIV_WAIT: begin
				w.cond = COND_DIV_BUSY;
				w.target = PC_DIV_WAIT;
			end
			PC_CHECK: begin
				w.step_div = 1'b1;
				w.cond = COND_REM_ZERO;
				w.target = PC_NO;
			end
			PC_BACK: begin
				w.cond = COND_ALWAYS;
				w.target = PC_LOOP;
			end
			PC_YES: begin
				w.flag_wr = 1'b1;
				w.flag_val = 1'b1;
				w.cond = COND_NEVER;
			end
			PC_EMIT: begin
				w.emit = 1'b1;
				w.cond = COND_OUT_BLOCKED;
				w.target = PC_EMIT;
			end
			PC_RESTART: begin
				w.cond = COND_ALWAYS;
				w.target = PC_WAIT;
			end
			PC_NO: begin
				w.flag_wr = 1'b1;
				w.flag_val = 1'b0;
				w.cond = COND_NEVER;
			end
			PC_TO_EMIT: begin
				w.cond = COND_ALWAYS;
				w.target = PC_EMIT;
			end
			default: begin
				w.cond = COND_ALWAYS;
				w.target = PC_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/trial_division_prime_test.sv
// Channel  | Signals                                 | Payload, low bit first
// ---------+-----------------------------------------+-----------------------------------
// input    | s_axis_tvalid/tready/tdata              | tdata: candidate[31:0]
// output   | m_axis_tvalid/tready/tdata/tuser        | tdata: tested_value; tuser: prime
//
// A microcoded sequencer steps a 13-word control store; one request at a time.
// Each odd trial divisor is checked by the bit-serial remainder unit, which works on
// W = min(VALUE_WIDTH, 32) bits; each request also passes through classification
// and output steps.
// Reset (arst_n, asynchronous) clears the sequencer and the output valid flag.
// The next request is taken while a result still waits in the output register;
// a stalled output holds the sequencer in its emit step.
`default_nettype none

`include "trial_division_prime_test_defines.svh"

module trial_division_prime_test #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [tdpt_pkg::CAND_W-1:0] s_axis_tdata,  // candidate
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [tdpt_pkg::CAND_W-1:0]      m_axis_tdata,  // tested_value
	output logic                             m_axis_tuser   // prime_flag
);

	import tdpt_pkg::*;

	// Bits of the candidate that take part in the test.
	localparam int unsigned NW = (VALUE_WIDTH < CAND_W) ? VALUE_WIDTH : CAND_W;

	logic [PC_W-1:0] pc_q;
	logic [NW-1:0]   n_q;
	logic [NW-1:0]   d_q;
	logic [NW:0]     sq_q;
	logic            flag_q;
	logic [NW-1:0]   out_data_q;
	logic            out_flag_q;
	logic            out_valid_q;

	ctrl_t           word;
	logic            cond_true;
	logic            act;
	logic            div_start;
	logic            div_busy;
	logic [NW-1:0]   div_rem;
	logic            out_blocked;
	logic            emit_fire;

	assign word        = microcode(pc_q);
	assign out_blocked = out_valid_q && !m_axis_tready;

	// Condition select.
	always_comb begin
		case (word.cond)
			COND_NEVER:       cond_true = 1'b0;
			COND_ALWAYS:      cond_true = 1'b1;
			COND_NO_REQUEST:  cond_true = !s_axis_tvalid;
			COND_BELOW_TWO:   cond_true = (n_q < NW'(2));
			COND_IS_TWO:      cond_true = (n_q == NW'(2));
			COND_EVEN:        cond_true = !n_q[0];
			COND_SQ_ABOVE:    cond_true = (sq_q > {1'b0, n_q});
			COND_DIV_BUSY:    cond_true = div_busy;
			COND_REM_ZERO:    cond_true = (div_rem == '0);
			COND_OUT_BLOCKED: cond_true = out_blocked;
			default:          cond_true = 1'b0;
		endcase
	end

	// Actions of the current word apply only on fall-through.
	assign act       = !cond_true;
	assign div_start = word.div_start && act;
	assign emit_fire = word.emit && act;

	assign s_axis_tready = word.accept;

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else begin
			pc_q <= cond_true ? word.target : pc_q + PC_W'(1);
		end
	end

	// Candidate, trial divisor and its square.
	always_ff @(posedge clk) begin
		if (word.accept && act) begin
			n_q  <= s_axis_tdata[NW-1:0];
			d_q  <= NW'(3);
			sq_q <= (NW + 1)'(9);
		end else if (word.step_div && act) begin
			d_q  <= d_q + NW'(2);
			sq_q <= sq_q + {d_q[NW-2:0], 2'b00} + (NW + 1)'(4);
		end
	end

	// Verdict register.
	always_ff @(posedge clk) begin
		if (word.flag_wr && act) begin
			flag_q <= word.flag_val;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_data_q <= n_q;
			out_flag_q <= flag_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = CAND_W'(out_data_q);
	assign m_axis_tuser  = out_flag_q;

	// Remainder unit.
	tdpt_mod #(
		.W(NW)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (n_q),
		.divisor   (d_q),
		.busy      (div_busy),
		.remainder (div_rem)
	);

	// Checks.
	`TDPT_ASSERT_NOW(a_start_idle, div_start, !div_busy, "remainder unit restarted while busy")
	`TDPT_ASSERT_NEXT(a_start_busy, div_start, div_busy, "remainder unit did not start")
	`TDPT_ASSERT_NOW(a_no_overwrite, emit_fire, !out_blocked, "stalled result overwritten")
	`TDPT_ASSERT_NOW(a_prime_odd, m_axis_tvalid && m_axis_tuser,
		m_axis_tdata[0] || (m_axis_tdata == CAND_W'(2)), "even number other than two flagged prime")

endmodule

`default_nettype wire

// File: rtl/core/tdpt_mod.sv
`default_nettype none

// Bit-serial restoring remainder unit: one dividend bit per cycle.
module tdpt_mod #(
	parameter int unsigned W = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              busy,
	output logic [W-1:0]      remainder
);

	localparam int unsigned CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic [W-1:0]  dvd_q;
	logic [W-1:0]  dvs_q;
	logic [W-1:0]  rem_q;
	logic [W:0]    trial;
	logic [W:0]    diff;

	// Shift in the next dividend bit and subtract the divisor when it fits.
	always_comb begin
		trial = {rem_q, dvd_q[W-1]};
		diff  = trial - {1'b0, dvs_q};
	end

	// Bit counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[W-2:0], 1'b0};
			rem_q <= diff[W] ? trial[W-1:0] : diff[W-1:0];
		end
	end

	assign busy      = (cnt_q != '0);
	assign remainder = rem_q;

endmodule

`default_nettype wire
